/* sv/wemc_pkg.sv */
// ----------------------------------------------------------------------------
// Windowed extreme/mean compare: shared definitions
// Widths, register indexes, mode codes and the types passed between modules.
// ----------------------------------------------------------------------------
package wemc_pkg;

   // store geometry and counter width
   localparam int WINDOW_DEPTH = 64;
   localparam int COUNT_WIDTH  = 20;

   // field widths
   localparam int TIME_W    = 31;
   localparam int VALUE_W   = 32;
   localparam int DEPTH_W   = $clog2(WINDOW_DEPTH);
   localparam int FILL_W    = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W     = VALUE_W + DEPTH_W;
   localparam int PROD_W    = VALUE_W + FILL_W + 1;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 31;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COMPARE_MODE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STATISTIC_SELECT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH    = 2'd2;

   // compare mode codes
   localparam logic CMP_GT = 1'b0;
   localparam logic CMP_LT = 1'b1;

   // statistic codes (the unused code acts as the mean)
   localparam logic [1:0] STAT_MAX  = 2'd0;
   localparam logic [1:0] STAT_MIN  = 2'd1;
   localparam logic [1:0] STAT_MEAN = 2'd2;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_EVAL
   } state_type;

   // one stored sample
   typedef struct packed {
      logic        [TIME_W-1:0]  stamp;
      logic signed [VALUE_W-1:0] value;
   } entry_type;

   // chain movement: shift inserts at the head, rotate circulates the row
   typedef struct packed {
      logic shift;
      logic rotate;
   } chain_ctrl_type;

   // accumulator control
   typedef struct packed {
      logic clear;
      logic step;
      logic in_use;
   } acc_ctrl_type;

   // window statistics
   typedef struct packed {
      logic signed [VALUE_W-1:0] max_val;
      logic signed [VALUE_W-1:0] min_val;
      logic signed [SUM_W-1:0]   sum;
      logic        [FILL_W-1:0]  cnt;
   } stat_type;

endpackage

/* sv/wemc_req_if.sv */
// ----------------------------------------------------------------------------
// Sample request channel
// Valid/ready channel carrying one timestamped sample.
// ----------------------------------------------------------------------------
interface wemc_req_if import wemc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic        [TIME_W-1:0]  sample_time;
   logic signed [VALUE_W-1:0] sample_value;
   logic                      first_of_set;

   modport source (output valid, output sample_time, output sample_value,
                   output first_of_set, input ready);
   modport sink   (input valid, input sample_time, input sample_value,
                   input first_of_set, output ready);
endinterface

/* sv/wemc_rsp_if.sv */
// ----------------------------------------------------------------------------
// Compare result channel
// Valid/ready channel carrying the result for one sample.
// ----------------------------------------------------------------------------
interface wemc_rsp_if import wemc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   qualifies;
   logic [COUNT_WIDTH-1:0] match_count;
   logic                   window_empty;
   logic                   window_truncated;

   modport source (output valid, output qualifies, output match_count,
                   output window_empty, output window_truncated, input ready);
   modport sink   (input valid, input qualifies, input match_count,
                   input window_empty, input window_truncated, output ready);
endinterface

/* sv/wemc_cell.sv */
// ----------------------------------------------------------------------------
// Window store cell
// Holds one sample; loads from the upstream neighbor on insert, from the
// downstream neighbor on rotate, and holds otherwise.
// ----------------------------------------------------------------------------
module wemc_cell import wemc_pkg::*; (
   input  logic           clock,
   input  chain_ctrl_type ctrl,
   input  entry_type      prev_entry,
   input  entry_type      next_entry,
   output entry_type      entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // load select
   always_comb begin
      if (ctrl.shift) begin
         entry_in = prev_entry;
      end else if (ctrl.rotate) begin
         entry_in = next_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

/* sv/wemc_chain.sv */
// ----------------------------------------------------------------------------
// Window store chain
// Row of cells, newest at cell 0. Insert pushes the row down and drops the
// last cell; rotate moves every entry one cell toward the head, wrapping
// cell 0 to the tail, so a full turn restores the order.
// ----------------------------------------------------------------------------
module wemc_chain import wemc_pkg::*; (
   input  logic           clock,
   input  chain_ctrl_type ctrl,
   input  entry_type      new_entry,
   output entry_type      head_entry,
   output entry_type      tail_entry
);

   entry_type cells [WINDOW_DEPTH];

   // cell row with neighbor wiring
   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      entry_type prev_entry;
      entry_type next_entry;

      if (i == 0) begin : g_head
         assign prev_entry = new_entry;
      end else begin : g_body
         assign prev_entry = cells[i-1];
      end

      if (i == WINDOW_DEPTH - 1) begin : g_tail
         assign next_entry = cells[0];
      end else begin : g_mid
         assign next_entry = cells[i+1];
      end

      wemc_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .entry      (cells[i])
      );
   end

   assign head_entry = cells[0];
   assign tail_entry = cells[WINDOW_DEPTH-1];

endmodule

/* sv/wemc_accum.sv */
// ----------------------------------------------------------------------------
// Window statistics accumulator
// Looks at the head cell once per scan step and folds in-window entries into
// running maximum, minimum, sum and count.
// ----------------------------------------------------------------------------
module wemc_accum import wemc_pkg::*; (
   input  logic               clock,
   input  acc_ctrl_type       ctrl,
   input  entry_type          head_entry,
   input  logic [TIME_W-1:0]  sample_time,
   input  logic [TIME_W-1:0]  window_length,
   output stat_type           stat
);

   stat_type stat_ff;
   stat_type stat_in;
   logic     in_window;
   logic     take;

   // window start below zero admits every stored sample
   assign in_window = (sample_time < window_length) ||
                      (head_entry.stamp >= (sample_time - window_length));
   assign take      = ctrl.step && ctrl.in_use && in_window;

   // fold one entry
   always_comb begin
      stat_in = stat_ff;
      if (ctrl.clear) begin
         stat_in.cnt = '0;
         stat_in.sum = '0;
      end else if (take) begin
         if ((stat_ff.cnt == '0) || (head_entry.value > stat_ff.max_val)) begin
            stat_in.max_val = head_entry.value;
         end
         if ((stat_ff.cnt == '0) || (head_entry.value < stat_ff.min_val)) begin
            stat_in.min_val = head_entry.value;
         end
         stat_in.sum = stat_ff.sum + SUM_W'(head_entry.value);
         stat_in.cnt = stat_ff.cnt + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      stat_ff <= stat_in;
   end

   assign stat = stat_ff;

endmodule

/* sv/windowed_extreme_mean_compare_unit.sv */
// ----------------------------------------------------------------------------
// Windowed extreme/mean compare unit
// Compares each sample with the max, min or mean of earlier samples in a
// sliding time window held in a row of shifting cells.
// ----------------------------------------------------------------------------
// A new request is taken only in the idle state, after the last one is through;
// the store is read by rotating the cell row one full turn past the accumulator.
// A finished result waits in the output register while the next request runs.
// Reset: synchronous, active high; clears control, fill level, count, result
//   valid and configuration registers. The cell contents are not cleared; the
//   fill level gates them.
// ----------------------------------------------------------------------------
module windowed_extreme_mean_compare_unit import wemc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   wemc_req_if.sink             req_chan,
   wemc_rsp_if.source           rsp_chan,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_write_data
);

   // configuration registers
   logic              compare_mode_ff;
   logic [1:0]        statistic_select_ff;
   logic [TIME_W-1:0] window_length_ff;

   // sequencer and set state
   state_type              state_ff, state_in;
   logic [DEPTH_W-1:0]     scan_idx_ff;
   logic [FILL_W-1:0]      fill_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic                   drop_valid_ff;
   logic [TIME_W-1:0]      drop_time_ff;

   // captured request and product
   logic        [TIME_W-1:0]  req_time_ff;
   logic signed [VALUE_W-1:0] req_value_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;

   // result register
   logic                   rsp_valid_ff;
   logic                   rsp_qual_ff;
   logic [COUNT_WIDTH-1:0] rsp_count_ff;
   logic                   rsp_empty_ff;
   logic                   rsp_trunc_ff;

   // control
   logic           req_fire;
   logic           scan_last;
   logic           slot_free;
   logic           eval_fire;
   chain_ctrl_type chain_ctrl;
   acc_ctrl_type   acc_ctrl;
   entry_type      new_entry;
   entry_type      head_entry;
   entry_type      tail_entry;
   stat_type       stat;

   // evaluation
   logic                     empty;
   logic                     trunc;
   logic                     qual;
   logic signed [PROD_W-1:0] lhs;
   logic signed [PROD_W-1:0] rhs;
   logic [COUNT_WIDTH-1:0]   count_next;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign scan_last = (scan_idx_ff == DEPTH_W'(WINDOW_DEPTH - 1));
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign eval_fire = (state_ff == ST_EVAL) && slot_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_chan.valid) state_in = ST_SCAN;
         ST_SCAN: if (scan_last) state_in = ST_MUL;
         ST_MUL:  state_in = ST_EVAL;
         ST_EVAL: if (slot_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready    = 1'b0;
      chain_ctrl.shift  = 1'b0;
      chain_ctrl.rotate = 1'b0;
      acc_ctrl.clear    = 1'b0;
      acc_ctrl.step     = 1'b0;
      acc_ctrl.in_use   = ({1'b0, scan_idx_ff} < fill_ff);
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            acc_ctrl.clear = 1'b1;
         end
         ST_SCAN: begin
            chain_ctrl.rotate = 1'b1;
            acc_ctrl.step     = 1'b1;
         end
         ST_MUL: begin
         end
         ST_EVAL: begin
            chain_ctrl.shift = slot_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         compare_mode_ff     <= 1'b0;
         statistic_select_ff <= 2'd0;
         window_length_ff    <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_COMPARE_MODE:     compare_mode_ff     <= csr_write_data[0];
            CSR_STATISTIC_SELECT: statistic_select_ff <= csr_write_data[1:0];
            CSR_WINDOW_LENGTH:    window_length_ff    <= csr_write_data[TIME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_time_ff  <= req_chan.sample_time;
         req_value_ff <= req_chan.sample_value;
      end
   end

   // scan step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
      end else if (req_fire) begin
         scan_idx_ff <= '0;
      end else if (state_ff == ST_SCAN) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
      end
   end

   // cell row and accumulator
   assign new_entry.stamp = req_time_ff;
   assign new_entry.value = req_value_ff;

   wemc_chain u_chain (
      .clock      (clock),
      .ctrl       (chain_ctrl),
      .new_entry  (new_entry),
      .head_entry (head_entry),
      .tail_entry (tail_entry)
   );

   wemc_accum u_accum (
      .clock         (clock),
      .ctrl          (acc_ctrl),
      .head_entry    (head_entry),
      .sample_time   (req_time_ff),
      .window_length (window_length_ff),
      .stat          (stat)
   );

   // mean product: sample value times window count
   assign prod_in = $signed(req_value_ff) * $signed({1'b0, stat.cnt});

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         prod_ff <= prod_in;
      end
   end

   // comparison
   always_comb begin
      case (statistic_select_ff)
         STAT_MAX: begin
            lhs = PROD_W'(req_value_ff);
            rhs = PROD_W'(stat.max_val);
         end
         STAT_MIN: begin
            lhs = PROD_W'(req_value_ff);
            rhs = PROD_W'(stat.min_val);
         end
         default: begin
            lhs = prod_ff;
            rhs = PROD_W'(stat.sum);
         end
      endcase
   end

   assign empty = (stat.cnt == '0);
   assign trunc = drop_valid_ff &&
                  ((req_time_ff < window_length_ff) ||
                   (drop_time_ff >= (req_time_ff - window_length_ff)));
   assign qual  = !empty && ((compare_mode_ff == CMP_LT) ? (lhs < rhs) : (lhs > rhs));
   assign count_next = (qual && (count_ff != '1)) ? count_ff + 1'b1 : count_ff;

   // set state: cleared by a first-of-set request, updated on evaluation
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         count_ff      <= '0;
         drop_valid_ff <= 1'b0;
      end else if (req_fire && req_chan.first_of_set) begin
         fill_ff       <= '0;
         count_ff      <= '0;
         drop_valid_ff <= 1'b0;
      end else if (eval_fire) begin
         count_ff <= count_next;
         if (fill_ff == FILL_W'(WINDOW_DEPTH)) begin
            drop_valid_ff <= 1'b1;
         end else begin
            fill_ff <= fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (eval_fire && (fill_ff == FILL_W'(WINDOW_DEPTH))) begin
         drop_time_ff <= tail_entry.stamp;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eval_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (eval_fire) begin
         rsp_qual_ff  <= qual;
         rsp_count_ff <= count_next;
         rsp_empty_ff <= empty;
         rsp_trunc_ff <= trunc;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.qualifies        = rsp_qual_ff;
   assign rsp_chan.match_count      = rsp_count_ff;
   assign rsp_chan.window_empty     = rsp_empty_ff;
   assign rsp_chan.window_truncated = rsp_trunc_ff;

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WINDOW_DEPTH))
      else $error("fill level above store depth");

   a_eval_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL && rsp_valid_ff && !rsp_chan.ready) |=> state_ff == ST_EVAL)
      else $error("result overwrote a pending response");

   a_qual_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_qual_ff && rsp_empty_ff))
      else $error("empty window reported as qualifying");

   a_scan_full_turn: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && !scan_last) |=> state_ff == ST_SCAN)
      else $error("scan ended before a full rotation");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_qual_ff) |-> rsp_count_ff != '0)
      else $error("qualifying result with zero count");

endmodule
